### src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and types of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Store geometry
    localparam int NUM_BLOCKS = 32768;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = NUM_BLOCKS / WORD_BITS;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int BLK_W      = 15;
    localparam int CNT_W      = 16;
    localparam int LWC_W      = 11;
    localparam int NBITS_W    = BIT_W + 1;
    localparam int CFG_IDX_W  = 2;

    localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

    // Command codes
    localparam logic [1:0] CMD_ALLOC      = 2'd0;
    localparam logic [1:0] CMD_FREE       = 2'd1;
    localparam logic [1:0] CMD_RANGE_FREE = 2'd2;
    localparam logic [1:0] CMD_RANGE_USED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_WORDS    = 2'd2;

    typedef logic [1:0]           cmd_t;
    typedef logic [BLK_W-1:0]     blk_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [WADDR_W-1:0]   waddr_t;
    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [BIT_W-1:0]     bitpos_t;

    // Word modify operations
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_SET,
        OP_CLEAR
    } word_op_t;

    typedef struct packed {
        word_op_t op;
        bitpos_t  lo;
        bitpos_t  hi;
    } word_ctl_t;

    typedef struct packed {
        word_t                wdata;
        logic                 hit;
        bitpos_t              bit_idx;
        logic [NBITS_W-1:0]   nbits;
    } word_res_t;

endpackage

### src/bfa_ifs.sv
// ----------------------------------------------------------------------------
// bfa interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfa_req_if;
    import bfa_pkg::*;
    logic  valid;
    logic  ready;
    cmd_t  cmd;
    blk_t  block_index;
    cnt_t  block_count;

    modport source (output valid, cmd, block_index, block_count, input ready);
    modport sink   (input valid, cmd, block_index, block_count, output ready);
endinterface

interface bfa_rsp_if;
    import bfa_pkg::*;
    logic  valid;
    logic  ready;
    logic  ok;
    blk_t  found_block;
    cnt_t  used_count;

    modport source (output valid, ok, found_block, used_count, input ready);
    modport sink   (input valid, ok, found_block, used_count, output ready);
endinterface

interface bfa_cfg_if;
    import bfa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/bfa_word_ops.sv
// ----------------------------------------------------------------------------
// bfa_word_ops
// Modify one bitmap word: find and set the lowest free bit, or set/clear a
// run of bits, and report how many bits the operation covered.
// ----------------------------------------------------------------------------
module bfa_word_ops (
    input  bfa_pkg::word_t    rdata,
    input  bfa_pkg::word_ctl_t ctl,
    output bfa_pkg::word_res_t res
);
    import bfa_pkg::*;

    logic    zero_found;
    bitpos_t zero_pos;
    word_t   run_mask;
    word_t   lo_mask;
    word_t   hi_mask;

    // Lowest zero bit
    always_comb
    begin
        zero_found = 1'b0;
        zero_pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rdata[i])
            begin
                zero_found = 1'b1;
                zero_pos   = BIT_W'(i);
            end
        end
    end

    // Run of bits from lo to hi inclusive
    assign lo_mask  = FULL_WORD << ctl.lo;
    assign hi_mask  = FULL_WORD >> (BIT_W'(WORD_BITS - 1) - ctl.hi);
    assign run_mask = lo_mask & hi_mask;

    // Build modified word
    always_comb
    begin
        res.hit     = zero_found;
        res.bit_idx = zero_pos;
        case (ctl.op)
            OP_ALLOC:
            begin
                res.wdata = rdata | (word_t'(1) << zero_pos);
                res.nbits = NBITS_W'(1);
            end
            OP_SET:
            begin
                res.wdata = rdata | run_mask;
                res.nbits = NBITS_W'(ctl.hi) - NBITS_W'(ctl.lo) + NBITS_W'(1);
            end
            OP_CLEAR:
            begin
                res.wdata = rdata & ~run_mask;
                res.nbits = NBITS_W'(ctl.hi) - NBITS_W'(ctl.lo) + NBITS_W'(1);
            end
            default:
            begin
                res.wdata = rdata;
                res.nbits = '0;
            end
        endcase
    end

endmodule

### src/bitmap_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// Bitmap block allocator: allocate, free and range mark over a word RAM.
// ----------------------------------------------------------------------------
// An allocate scans words up to the first free bit, at most 1024 words; a free
// or range walks the words it spans; a refused allocate or an empty range reads
// no word. One command is in work at a time, one RAM read per cycle, and
// the next command enters while the previous response waits at the output.
// Reset: a sweep marks every block used; commands wait for it to
// end, configuration writes do not.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core (
    input  logic          clk,
    input  logic          rst_n,
    bfa_req_if.sink       req,
    bfa_rsp_if.source     rsp,
    bfa_cfg_if.sink       cfg
);
    import bfa_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ALLOC = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [CNT_W-1:0] TOTAL_MAX = CNT_W'(NUM_BLOCKS);

    // Configuration registers
    logic [CNT_W-1:0] total_reg;
    logic             low_mode_reg;
    logic [LWC_W-1:0] low_words_reg;

    // Sequencer state
    logic [2:0]        state_reg, state_next;
    logic [WADDR_W:0]  addr_reg, addr_next;
    logic              issue_end_reg, issue_end_next;
    logic              pend_vld_reg, pend_vld_next;
    waddr_t            pend_addr_reg, pend_addr_next;
    waddr_t            first_reg, first_next;
    waddr_t            last_reg, last_next;
    bitpos_t           lo_reg, lo_next;
    bitpos_t           hi_reg, hi_next;
    logic              set_reg, set_next;
    cnt_t              count_reg, count_next;
    logic              res_ok_reg, res_ok_next;
    blk_t              res_found_reg, res_found_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    blk_t              out_found_reg, out_found_next;
    cnt_t              out_count_reg, out_count_next;

    // RAM and word unit
    logic              ram_we;
    waddr_t            ram_waddr;
    word_t             ram_wdata;
    word_t             ram_rdata;
    word_ctl_t         wctl;
    word_res_t         wres;

    // Command decode
    logic              accept;
    cnt_t              eff_total;
    logic [LWC_W-1:0]  limit;
    logic [BLK_W+1:0]  range_sum;
    blk_t              last_blk;
    logic [CNT_W:0]    up_sum;
    cnt_t              count_upd;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg[WADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    bfa_word_ops u_word_ops (
        .rdata (ram_rdata),
        .ctl   (wctl),
        .res   (wres)
    );

    // Handshakes
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.found_block = out_found_reg;
    assign rsp.used_count  = out_count_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= TOTAL_MAX;
            low_mode_reg  <= 1'b1;
            low_words_reg <= LWC_W'(32);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_TOTAL_BLOCKS: total_reg     <= cfg.data;
                REG_LOW_MODE:     low_mode_reg  <= cfg.data[0];
                REG_LOW_WORDS:    low_words_reg <= cfg.data[LWC_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective total and scan limit
    always_comb
    begin
        eff_total = (total_reg > TOTAL_MAX) ? TOTAL_MAX : total_reg;
        if (low_mode_reg)
        begin
            limit = (low_words_reg > LWC_W'(MAP_WORDS)) ? LWC_W'(MAP_WORDS)
                                                          : low_words_reg;
        end
        else
        begin
            limit = LWC_W'(eff_total >> BIT_W);
        end
    end

    // Last block of a range, clipped to the store
    always_comb
    begin
        range_sum = (BLK_W+2)'(req.block_index) + (BLK_W+2)'(req.block_count)
                    - (BLK_W+2)'(1);
        last_blk  = (range_sum >= (BLK_W+2)'(NUM_BLOCKS)) ? BLK_W'(NUM_BLOCKS - 1)
                                                           : range_sum[BLK_W-1:0];
    end

    // Word unit control
    always_comb
    begin
        wctl.op = (state_reg == ST_ALLOC) ? OP_ALLOC : (set_reg ? OP_SET : OP_CLEAR);
        wctl.lo = (pend_addr_reg == first_reg) ? lo_reg : '0;
        wctl.hi = (pend_addr_reg == last_reg) ? hi_reg : BIT_W'(WORD_BITS - 1);
    end

    // Saturating counter adjust by the bits one word covers
    always_comb
    begin
        up_sum = (CNT_W+1)'(count_reg) + (CNT_W+1)'(wres.nbits);
        if (set_reg)
        begin
            if (count_reg >= eff_total)
            begin
                count_upd = count_reg;
            end
            else if (up_sum > (CNT_W+1)'(eff_total))
            begin
                count_upd = eff_total;
            end
            else
            begin
                count_upd = up_sum[CNT_W-1:0];
            end
        end
        else
        begin
            count_upd = (count_reg > CNT_W'(wres.nbits)) ? count_reg - CNT_W'(wres.nbits)
                                                        : '0;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        issue_end_next = issue_end_reg;
        pend_vld_next  = 1'b0;
        pend_addr_next = pend_addr_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        set_next       = set_reg;
        count_next     = count_reg;
        res_ok_next    = res_ok_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_found_next = out_found_reg;
        out_count_next = out_count_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = wres.wdata;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep ones into every word
                ram_we    = 1'b1;
                ram_waddr = addr_reg[WADDR_W-1:0];
                ram_wdata = FULL_WORD;
                addr_next = addr_reg + (WADDR_W+1)'(1);
                if (addr_reg[WADDR_W-1:0] == WADDR_W'(MAP_WORDS - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    issue_end_next = 1'b0;
                    res_found_next = '0;
                    res_ok_next    = 1'b1;
                    case (req.cmd)
                        CMD_ALLOC:
                        begin
                            set_next   = 1'b1;
                            first_next = '0;
                            last_next  = WADDR_W'(limit - LWC_W'(1));
                            addr_next  = '0;
                            if ((count_reg >= eff_total) || (limit == '0))
                            begin
                                res_ok_next = 1'b0;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_ALLOC;
                            end
                        end
                        CMD_FREE:
                        begin
                            set_next   = 1'b0;
                            first_next = req.block_index[BLK_W-1:BIT_W];
                            last_next  = req.block_index[BLK_W-1:BIT_W];
                            lo_next    = req.block_index[BIT_W-1:0];
                            hi_next    = req.block_index[BIT_W-1:0];
                            addr_next  = {1'b0, req.block_index[BLK_W-1:BIT_W]};
                            state_next = ST_RANGE;
                        end
                        default:
                        begin
                            set_next   = (req.cmd == CMD_RANGE_USED);
                            first_next = req.block_index[BLK_W-1:BIT_W];
                            last_next  = last_blk[BLK_W-1:BIT_W];
                            lo_next    = req.block_index[BIT_W-1:0];
                            hi_next    = last_blk[BIT_W-1:0];
                            addr_next  = {1'b0, req.block_index[BLK_W-1:BIT_W]};
                            state_next = (req.block_count == '0) ? ST_DONE : ST_RANGE;
                        end
                    endcase
                end
            end

            ST_ALLOC, ST_RANGE:
            begin
                // Issue one read per cycle until the last word
                if (!issue_end_reg)
                begin
                    addr_next      = addr_reg + (WADDR_W+1)'(1);
                    pend_vld_next  = 1'b1;
                    pend_addr_next = addr_reg[WADDR_W-1:0];
                    if (addr_reg[WADDR_W-1:0] == last_reg)
                    begin
                        issue_end_next = 1'b1;
                    end
                end

                // Modify and write back the word that arrived
                if (pend_vld_reg)
                begin
                    if (state_reg == ST_ALLOC)
                    begin
                        if (wres.hit)
                        begin
                            ram_we         = 1'b1;
                            count_next     = count_reg + CNT_W'(1);
                            res_ok_next    = 1'b1;
                            res_found_next = {pend_addr_reg, wres.bit_idx};
                            pend_vld_next  = 1'b0;
                            state_next     = ST_DONE;
                        end
                        else if (pend_addr_reg == last_reg)
                        begin
                            res_ok_next   = 1'b0;
                            pend_vld_next = 1'b0;
                            state_next    = ST_DONE;
                        end
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_upd;
                        if (pend_addr_reg == last_reg)
                        begin
                            pend_vld_next = 1'b0;
                            state_next    = ST_DONE;
                        end
                    end
                end
            end

            ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_found_next = res_ok_reg ? res_found_reg : '0;
                    out_count_next = count_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            issue_end_reg <= 1'b0;
            pend_vld_reg  <= 1'b0;
            count_reg     <= CNT_W'(NUM_BLOCKS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            issue_end_reg <= issue_end_next;
            pend_vld_reg  <= pend_vld_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        set_reg       <= set_next;
        res_ok_reg    <= res_ok_next;
        res_found_reg <= res_found_next;
        out_ok_reg    <= out_ok_next;
        out_found_reg <= out_found_next;
        out_count_reg <= out_count_next;
    end

    // Counter never exceeds the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_BLOCKS))
        else $error("used counter above store size");

    // No bitmap write while no command is in work
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !ram_we)
        else $error("bitmap write outside a command");

    // A pending read only exists during a scan or walk
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (state_reg == ST_ALLOC || state_reg == ST_RANGE))
        else $error("pending read outside scan");

    // A successful allocate write ends the scan
    a_alloc_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == ST_ALLOC) |=> (state_reg == ST_DONE))
        else $error("allocate did not finish after its write");

    // A failed response carries no block
    a_fail_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.found_block == '0))
        else $error("failed response with a block index");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap frame allocator core. Commands go in on
// the request channel with bursty timing and results come back on a stalling
// response channel. An in-bench bitmap and usage counter predict every result.
// Directed tests cover the store-full and empty-window cases, range walks
// across the store end, counter saturation and register extremes. Random
// phases under several register settings follow, plus one long output
// back-pressure stretch.
// ----------------------------------------------------------------------------
module tb;
    import bfa_pkg::*;

    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int HOLD_CYCLES      = 300;
    localparam int TAIL_CYCLES      = 1100;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int GRANT_KEEP       = 64;
    localparam int MAX_PRINTED      = 40;

    typedef struct {
        logic ok;
        blk_t found_block;
        cnt_t used_count;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();
    bfa_cfg_if cfg_ch ();

    bitmap_frame_allocator_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predicted allocator state
    word_t       map_words [MAP_WORDS];
    int unsigned used_blocks;
    int unsigned cfg_total;
    logic        cfg_low_mode;
    int unsigned cfg_low_words;
    blk_t        granted_blocks[$];
    alloc_rsp_t  pending_rsp[$];
    alloc_rsp_t  rsp_want;

    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left  = 8;
    bit          gapless     = 1'b0;
    logic [9:0]  ready_phase = '0;
    bit          hold_req    = 1'b0;
    bit          hold_ack    = 1'b0;
    int          hold_left   = 0;

    always #5 clk = ~clk;

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR %0t: %s", $time, msg);
    endtask

    function automatic int unsigned effective_total();
        return (cfg_total > NUM_BLOCKS) ? NUM_BLOCKS : cfg_total;
    endfunction

    function automatic void count_up();
        if (used_blocks < effective_total())
            used_blocks++;
    endfunction

    function automatic void count_down();
        if (used_blocks > 0)
            used_blocks--;
    endfunction

    function automatic void reset_model();
        foreach (map_words[w])
            map_words[w] = FULL_WORD;
        used_blocks   = NUM_BLOCKS;
        cfg_total     = 32768;
        cfg_low_mode  = 1'b1;
        cfg_low_words = 32;
        granted_blocks.delete();
        pending_rsp.delete();
    endfunction

    // Apply one command to the predicted bitmap and return its response
    function automatic alloc_rsp_t apply_allocator_cmd(cmd_t c, blk_t idx, cnt_t cnt);
        alloc_rsp_t  r;
        int unsigned limit;
        int unsigned blk;
        int unsigned w;
        int unsigned b;
        int unsigned k;
        r.ok          = 1'b1;
        r.found_block = '0;
        case (c)
            CMD_ALLOC:
            begin
                r.ok = 1'b0;
                if (used_blocks < effective_total())
                begin
                    if (cfg_low_mode)
                        limit = (cfg_low_words > MAP_WORDS) ? MAP_WORDS : cfg_low_words;
                    else
                        limit = effective_total() / WORD_BITS;
                    // Lowest clear bit in the lowest word that is not full
                    for (w = 0; w < limit && !r.ok; w++)
                    begin
                        if (map_words[w] == FULL_WORD)
                            continue;
                        for (b = 0; b < WORD_BITS; b++)
                        begin
                            if (!map_words[w][b])
                            begin
                                r.found_block = blk_t'(w * WORD_BITS + b);
                                r.ok          = 1'b1;
                                break;
                            end
                        end
                    end
                    if (r.ok)
                    begin
                        map_words[r.found_block / WORD_BITS][r.found_block % WORD_BITS] = 1'b1;
                        count_up();
                        if (granted_blocks.size() < GRANT_KEEP)
                            granted_blocks.push_back(r.found_block);
                    end
                end
            end
            CMD_FREE:
            begin
                map_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                count_down();
            end
            default:
            begin
                // Walk the range; stop at the end of the store
                for (k = 0; k < cnt; k++)
                begin
                    blk = idx + k;
                    if (blk >= NUM_BLOCKS)
                        break;
                    map_words[blk / WORD_BITS][blk % WORD_BITS] = (c == CMD_RANGE_USED);
                    if (c == CMD_RANGE_USED)
                        count_up();
                    else
                        count_down();
                end
            end
        endcase
        r.used_count = cnt_t'(used_blocks);
        return r;
    endfunction

    function automatic blk_t rand_block();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return blk_t'($urandom_range(0, 511));
        else if (pick < 90)
            return blk_t'($urandom_range(0, NUM_BLOCKS - 1));
        return blk_t'($urandom_range(NUM_BLOCKS - 70, NUM_BLOCKS - 1));
    endfunction

    function automatic cnt_t rand_count();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '0;
        else if (pick < 75)
            return cnt_t'($urandom_range(1, 40));
        else if (pick < 93)
            return cnt_t'($urandom_range(41, 600));
        else if (pick < 98)
            return cnt_t'($urandom_range(601, 4000));
        return cnt_t'($urandom_range(4001, 65535));
    endfunction

    // Offer one command transaction and predict its response on acceptance
    task automatic send_cmd(cmd_t c, blk_t idx, cnt_t cnt);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= c;
        req_ch.block_index <= idx;
        req_ch.block_count <= cnt;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_rsp.push_back(apply_allocator_cmd(c, idx, cnt));
        if (!gapless)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                // Drop valid for a random gap, then pick the next burst length
                req_ch.valid <= 1'b0;
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 4);
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 10);
            end
        end
    endtask

    task automatic send_random_cmd();
        int unsigned pick;
        int unsigned slot;
        blk_t        idx;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_cmd(CMD_ALLOC, rand_block(), rand_count());
        else if (pick < 65)
        begin
            // Free a block handed out earlier half of the time
            if (granted_blocks.size() != 0 && $urandom_range(0, 1))
            begin
                slot = $urandom_range(0, granted_blocks.size() - 1);
                idx  = granted_blocks[slot];
                granted_blocks.delete(slot);
            end
            else
                idx = rand_block();
            send_cmd(CMD_FREE, idx, rand_count());
        end
        else if (pick < 82)
            send_cmd(CMD_RANGE_FREE, rand_block(), rand_count());
        else
            send_cmd(CMD_RANGE_USED, rand_block(), rand_count());
    endtask

    // Stop offering and wait until every predicted response has arrived
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Write all three registers back to back, valid held across them
    task automatic write_config(cnt_t total, cnt_t low_mode_data, cnt_t low_words_data);
        logic [CFG_IDX_W-1:0] regs [3];
        cnt_t                 vals [3];
        regs = '{REG_TOTAL_BLOCKS, REG_LOW_MODE, REG_LOW_WORDS};
        vals = '{total, low_mode_data, low_words_data};
        for (int i = 0; i < 3; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid  <= 1'b0;
        cfg_total     = total;
        cfg_low_mode  = low_mode_data[0];
        cfg_low_words = low_words_data[LWC_W-1:0];
    endtask

    // Reset settings: store starts full, then a window with nothing free
    task automatic test_reset_state();
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_FREE, '0, '0);
        send_cmd(CMD_FREE, blk_t'(NUM_BLOCKS - 1), '1);
        send_cmd(CMD_ALLOC, '1, '1);
        send_cmd(CMD_ALLOC, '0, '0);
    endtask

    // Zero-length ranges, a range running off the store end, small ranges
    task automatic test_range_edges();
        send_cmd(CMD_RANGE_FREE, blk_t'(100), '0);
        send_cmd(CMD_RANGE_USED, blk_t'(200), '0);
        send_cmd(CMD_RANGE_FREE, blk_t'(NUM_BLOCKS - 8), 16'hFFFF);
        send_cmd(CMD_RANGE_USED, blk_t'(NUM_BLOCKS - 4), cnt_t'(4));
        send_cmd(CMD_RANGE_FREE, '0, cnt_t'(64));
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_RANGE_USED, '0, cnt_t'(64));
    endtask

    // Counter pinned at the total, drained to zero, then pinned again
    task automatic test_counter_saturation();
        settle();
        write_config(cnt_t'(40), '0, '0);
        send_cmd(CMD_RANGE_USED, '0, cnt_t'(3));
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_RANGE_FREE, '0, cnt_t'(NUM_BLOCKS));
        send_cmd(CMD_FREE, blk_t'(5), '0);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_RANGE_USED, '0, cnt_t'(64));
        send_cmd(CMD_ALLOC, '0, '0);
    endtask

    // Oversized total, empty low window, oversized low window
    task automatic test_config_extremes();
        settle();
        write_config(16'hFFFF, cnt_t'(1), '0);
        send_cmd(CMD_ALLOC, '0, '0);
        settle();
        write_config(16'hFFFF, cnt_t'(1), cnt_t'(2047));
        send_cmd(CMD_RANGE_USED, blk_t'(32), cnt_t'(NUM_BLOCKS - 32));
        send_cmd(CMD_RANGE_FREE, blk_t'(NUM_BLOCKS - 1), cnt_t'(1));
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_ALLOC, '0, '0);
    endtask

    // Random command mix under several register settings
    task automatic test_random_traffic();
        cnt_t totals  [6] = '{16'd32768, 16'd512, 16'd32768, 16'hFFFF, 16'd0, 16'd0};
        cnt_t modes   [6] = '{16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFE};
        cnt_t windows [6] = '{16'd2, 16'd0, 16'hFFFF, 16'd1024, 16'd0, 16'd7};
        for (int p = 0; p < 6; p++)
        begin
            settle();
            if (p == 4)
                write_config(cnt_t'($urandom_range(32, 4000)), cnt_t'($urandom_range(0, 1)),
                             cnt_t'($urandom_range(0, 40)));
            else
                write_config(totals[p], modes[p], windows[p]);
            // Clear the store so that each setting starts from free blocks
            send_cmd(CMD_RANGE_FREE, '0, cnt_t'(NUM_BLOCKS));
            repeat (RANDOM_PER_PHASE) send_random_cmd();
        end
    endtask

    // Hold the response side off while commands keep coming
    task automatic test_output_backpressure();
        settle();
        hold_req <= ~hold_req;
        gapless = 1'b1;
        repeat (14) send_random_cmd();
        gapless = 1'b0;
    endtask

    // Long response hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req != hold_ack)
        begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
    end

    // Response ready: rotate through free-running, random and periodic stalls
    always @(posedge clk)
    begin
        ready_phase <= ready_phase + 1'b1;
        if (hold_left != 0)
            rsp_ch.ready <= 1'b0;
        else
            case (ready_phase[9:8])
                2'd0: rsp_ch.ready <= 1'b1;
                2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2'd2: rsp_ch.ready <= (ready_phase[2:0] != 3'd5);
                default: rsp_ch.ready <= ($urandom_range(0, 9) > 6);
            endcase
    end

    // Compare each response transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
                report_error($sformatf("response with no command outstanding: ok=%0d blk=%0d cnt=%0d",
                                       rsp_ch.ok, rsp_ch.found_block, rsp_ch.used_count));
            else
            begin
                rsp_want = pending_rsp.pop_front();
                if (rsp_ch.ok !== rsp_want.ok)
                    report_error($sformatf("ok got %0d expected %0d", rsp_ch.ok, rsp_want.ok));
                if (rsp_ch.found_block !== rsp_want.found_block)
                    report_error($sformatf("found_block got %0d expected %0d",
                                           rsp_ch.found_block, rsp_want.found_block));
                if (rsp_ch.used_count !== rsp_want.used_count)
                    report_error($sformatf("used_count got %0d expected %0d",
                                           rsp_ch.used_count, rsp_want.used_count));
            end
        end
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_ALLOC;
        req_ch.block_index = '0;
        req_ch.block_count = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_TOTAL_BLOCKS;
        cfg_ch.data        = '0;
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_range_edges();
        test_counter_saturation();
        test_config_extremes();
        test_random_traffic();
        test_output_backpressure();

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
src/bfa_pkg.sv
src/bfa_ifs.sv
src/bfa_ram.sv
src/bfa_word_ops.sv
src/bitmap_frame_allocator_core.sv
test/tb.sv
